// ===== hw/rtl/gaussian_3x3_filter_defines.svh =====
// Assertion macros shared by the checker of the 3x3 Gaussian filter.
// No dependencies; included by the checker file only.
`ifndef GAUSSIAN_3X3_FILTER_DEFINES_SVH
`define GAUSSIAN_3X3_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GF3_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GF3_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/gf3_pkg.sv =====
// Package of the 3x3 Gaussian filter: widths, register indexes and the
// position record passed from the position tracker to the window stage.
// No dependencies.
package gf3_pkg;

   // Line store depth and its address width.
   localparam int MaxWidth = 2048;
   localparam int AddrW    = $clog2(MaxWidth);

   // Field widths of the pixel stream.
   localparam int PixW = 8;
   localparam int ColW = 11;
   localparam int RowW = 12;
   localparam int CfgW = 12;

   // Smallest frame the block works with, and its largest width.
   localparam logic [CfgW-1:0] MinDim = CfgW'(16);
   localparam logic [CfgW-1:0] MaxDim = CfgW'(MaxWidth);

   // One line store entry holds the row above (low byte) and two above.
   localparam int EntryW = 2 * PixW;

   // Result beat: smoothed, column, row, packed from bit 0, one pad bit.
   localparam int RspW = 32;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_reg_type;

   // Position of the pixel entering the pipeline.
   typedef struct packed {
      logic            valid;     // pixel belongs to an active frame
      logic [ColW-1:0] col;
      logic [RowW-1:0] row;
      logic            interior;  // a result is due with this pixel
      logic            last;      // final pixel of the frame
   } pos_type;

endpackage

// ===== hw/rtl/gf3_line_ram.sv =====
// Two-row line store of the 3x3 Gaussian filter: one synchronous RAM,
// one write and one registered read per cycle. Uses gf3_pkg.
module gf3_line_ram (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [gf3_pkg::AddrW-1:0]  rd_addr,
   output logic [gf3_pkg::EntryW-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [gf3_pkg::AddrW-1:0]  wr_addr,
   input  logic [gf3_pkg::EntryW-1:0] wr_data
);
   import gf3_pkg::*;

   logic [EntryW-1:0] ram_ff [MaxWidth];
   logic [EntryW-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds while not enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

// ===== hw/rtl/gf3_ctrl.sv =====
// Configuration registers and raster position tracking of the 3x3
// Gaussian filter. Uses gf3_pkg.
module gf3_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [gf3_pkg::CfgW-1:0] csr_wdata,
   input  logic                     take,
   input  logic                     start,
   output gf3_pkg::pos_type         pos
);
   import gf3_pkg::*;

   logic [CfgW-1:0] width_ff, width_in;
   logic [CfgW-1:0] height_ff, height_in;
   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;
   logic            active_ff, active_in;

   logic [CfgW-1:0] eff_w;
   logic [CfgW-1:0] eff_h;
   logic [ColW-1:0] cur_col;
   logic [RowW-1:0] cur_row;
   logic            cur_active;
   logic            row_end;
   logic            frame_end;

   // Register writes.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the frame size into the supported range.
   always_comb begin
      if (width_ff < MinDim) begin
         eff_w = MinDim;
      end else if (width_ff > MaxDim) begin
         eff_w = MaxDim;
      end else begin
         eff_w = width_ff;
      end
      eff_h = (height_ff < MinDim) ? MinDim : height_ff;
   end

   // Position of the incoming pixel; a frame start restarts at the origin.
   always_comb begin
      cur_col    = start ? '0 : col_ff;
      cur_row    = start ? '0 : row_ff;
      cur_active = start | active_ff;
      row_end    = CfgW'(cur_col) >= (eff_w - CfgW'(1));
      frame_end  = row_end && (cur_row >= (eff_h - CfgW'(1)));

      pos.valid    = cur_active;
      pos.col      = cur_col;
      pos.row      = cur_row;
      pos.interior = (cur_col >= ColW'(2)) && (cur_row >= RowW'(2));
      pos.last     = frame_end;
   end

   // Advance the raster counters on each pixel taken in an active frame.
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      active_in = active_ff;
      if (take && cur_active) begin
         if (frame_end) begin
            col_in    = '0;
            row_in    = '0;
            active_in = 1'b0;
         end else if (row_end) begin
            col_in    = '0;
            row_in    = cur_row + RowW'(1);
            active_in = 1'b1;
         end else begin
            col_in    = cur_col + ColW'(1);
            row_in    = cur_row;
            active_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CfgW'(640);
         height_ff <= CfgW'(480);
         col_ff    <= '0;
         row_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         active_ff <= active_in;
      end
   end

endmodule

// ===== hw/rtl/gf3_window.sv =====
// Window stage of the 3x3 Gaussian filter: line store read-modify-write
// with forwarding, the 3x3 window, the weighted sum and the result
// register. Uses gf3_pkg.
module gf3_window (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       take,
   input  logic [gf3_pkg::PixW-1:0]   pixel,
   input  gf3_pkg::pos_type           pos,
   input  logic [gf3_pkg::EntryW-1:0] ram_rdata,
   output logic                       ram_we,
   output logic [gf3_pkg::AddrW-1:0]  ram_waddr,
   output logic [gf3_pkg::EntryW-1:0] ram_wdata,
   output logic                       rsp_tvalid,
   output logic [gf3_pkg::RspW-1:0]   rsp_tdata,
   output logic                       rsp_tlast
);
   import gf3_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [PixW-1:0]   s1_pix_ff;
   pos_type           s1_pos_ff;
   logic              fwd_ff, fwd_in;
   logic [EntryW-1:0] fwd_data_ff;
   logic [PixW-1:0]   win_ff [6];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RspW-1:0]   rsp_data_ff;
   logic              rsp_last_ff;

   logic [EntryW-1:0] entry;
   logic [PixW-1:0]   top;
   logic [PixW-1:0]   mid;
   logic [11:0]       col_l;
   logic [11:0]       col_c;
   logic [11:0]       col_r;
   logic [11:0]       sum;
   logic [11:0]       sum_rnd;
   logic [ColW-1:0]   out_col;
   logic [RowW-1:0]   out_row;

   // Stored rows of the current column, taken from the bypass when the
   // previous beat wrote the same entry in the cycle of this read.
   always_comb begin
      entry = fwd_ff ? fwd_data_ff : ram_rdata;
      top   = entry[EntryW-1:PixW];
      mid   = entry[PixW-1:0];
   end

   // Shift the rows down one step in the line store.
   assign ram_we    = adv && s1_valid_ff;
   assign ram_waddr = AddrW'(s1_pos_ff.col);
   assign ram_wdata = {mid, s1_pix_ff};

   // Bypass when the next beat reads the entry written now.
   assign fwd_in = s1_valid_ff && (AddrW'(pos.col) == AddrW'(s1_pos_ff.col));

   // Column sums with 1-2-1 weights, then 1-2-1 across columns.
   always_comb begin
      col_l   = 12'(win_ff[0]) + 12'({win_ff[1], 1'b0}) + 12'(win_ff[2]);
      col_c   = 12'(win_ff[3]) + 12'({win_ff[4], 1'b0}) + 12'(win_ff[5]);
      col_r   = 12'(top) + 12'({mid, 1'b0}) + 12'(s1_pix_ff);
      sum     = col_l + {col_c[10:0], 1'b0} + col_r;
      sum_rnd = sum + 12'd8;
      out_col = s1_pos_ff.col - ColW'(1);
      out_row = s1_pos_ff.row - RowW'(1);
   end

   assign s1_valid_in  = take && pos.valid;
   assign rsp_valid_in = s1_valid_ff && s1_pos_ff.interior;

   // Control registers of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_valid_in) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   // Payload of the read stage and the bypass.
   always_ff @(posedge clock) begin
      if (adv && s1_valid_in) begin
         s1_pix_ff   <= pixel;
         s1_pos_ff   <= pos;
         fwd_data_ff <= ram_wdata;
      end
   end

   // Window of the two previous columns, moved by every framed pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (adv && s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= s1_pix_ff;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (adv && rsp_valid_in) begin
         rsp_data_ff <= {1'b0, out_row, out_col, sum_rnd[11:4]};
         rsp_last_ff <= s1_pos_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/gaussian_3x3_filter.sv =====
// 3x3 binomial smoothing of a gray pixel stream: usage notes below.
// Top level; uses gf3_pkg, gf3_ctrl, gf3_line_ram and gf3_window.
//
// Pixels enter on the req_ stream in raster order, one per beat; tuser
// marks the first pixel of a frame and restarts the raster position.
// Pixels that arrive after the end of a frame and before the next frame
// start are dropped. For every interior pixel (not on the frame border)
// one beat leaves on rsp_ carrying the smoothed value, its column and row;
// tlast is set on the last interior pixel of the frame. Border results
// are not produced.
// The user must write width and height on csr_ while the block is idle;
// the block does not enforce it. Widths clamp to 16..2048, heights to >= 16.
// Throughput is one pixel per cycle while rsp_ is not stalled. A result is
// valid on rsp_ after the pixel below and to the right of it is taken and
// the weighted sum is registered: the line store read is registered when
// the pixel is taken, and the weighted sum then enters the output register.
// When rsp_tready is low with a result waiting, the whole pipeline holds
// and req_tready drops; it rises again with rsp_tready.
// Reset clears the position counters and the window and sets the frame
// size to 640 by 480; the line store keeps its contents and needs no pass.
module gaussian_3x3_filter (
   input  logic                       clock,
   input  logic                       reset,
   // Configuration writes.
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [gf3_pkg::CfgW-1:0]   csr_wdata,
   // Pixel stream.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [gf3_pkg::PixW-1:0]   req_tdata,   // [7:0] pixel
   input  logic                       req_tuser,   // [0] frame_start
   // Result stream.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [gf3_pkg::RspW-1:0]   rsp_tdata,   // [7:0] smoothed,
                                                   // [18:8] out_col,
                                                   // [30:19] out_row, [31] 0
   output logic                       rsp_tlast    // last
);
   import gf3_pkg::*;

   logic              adv;
   logic              take;
   pos_type           pos;
   logic [EntryW-1:0] ram_rdata;
   logic              ram_we;
   logic [AddrW-1:0]  ram_waddr;
   logic [EntryW-1:0] ram_wdata;

   // The pipeline moves whenever the result register is free or drains.
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign take       = req_tvalid && req_tready;

   gf3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .take      (take),
      .start     (req_tuser),
      .pos       (pos)
   );

   gf3_line_ram u_ram (
      .clock   (clock),
      .rd_en   (take && pos.valid),
      .rd_addr (AddrW'(pos.col)),
      .rd_data (ram_rdata),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata)
   );

   gf3_window u_window (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .take       (take),
      .pixel      (req_tdata),
      .pos        (pos),
      .ram_rdata  (ram_rdata),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/gf3_checker.sv =====
// Port-level checks of the 3x3 Gaussian filter and their binding.
// Uses gaussian_3x3_filter_defines.svh and gf3_pkg.
`include "gaussian_3x3_filter_defines.svh"

module gf3_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [gf3_pkg::RspW-1:0] rsp_tdata,
   input logic                     rsp_tlast
);
   import gf3_pkg::*;

   // A stalled result beat keeps its contents.
   `GF3_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
      "result beat changed while stalled")

   // With the result register empty the block is always ready for a pixel.
   `GF3_ASSERT_IMP(a_req_ready, clock, reset, !rsp_tvalid, req_tready,
      "input stalled with an empty result register")

   // Results are interior pixels only and the pad bit stays clear.
   `GF3_ASSERT_IMP(a_interior, clock, reset, rsp_tvalid,
      (rsp_tdata[18:8] != 11'd0) && (rsp_tdata[30:19] != 12'd0) && !rsp_tdata[31],
      "result on the frame border")

   // No result is pending right after reset.
   `GF3_ASSERT_IMP(a_reset_empty, clock, reset, $past(reset), !rsp_tvalid,
      "result valid right after reset")

endmodule

bind gaussian_3x3_filter gf3_checker u_gf3_checker (.*);

// ===== test/gaussian_3x3_filter_tb.sv =====
// Self-checking testbench of the 3x3 Gaussian filter: drives raster pixel frames of
// several sizes and checks every smoothed result beat against a behavioral predictor.
// Depends on gf3_pkg and the gaussian_3x3_filter top level.
`timescale 1ns / 100ps

module gaussian_3x3_filter_tb;

   import gf3_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_PCT    = 38;
   localparam int ITEM_TARGET = 1950;

   // Pixel content of one frame.
   typedef enum int {
      PIX_RANDOM,
      PIX_BLACK,
      PIX_WHITE,
      PIX_CHECKER,
      PIX_EXTREME
   } pix_mode_type;

   // One smoothed output pixel.
   typedef struct packed {
      logic [PixW-1:0] smoothed;
      logic [ColW-1:0] col;
      logic [RowW-1:0] row;
      logic            last;
   } blur_result_type;

   // Tracks the raster position, line stores and window of the filter and
   // holds the smoothed pixels still due from the block.
   class blur_predictor;
      logic [CfgW-1:0]  width_reg;
      logic [CfgW-1:0]  height_reg;
      logic [PixW-1:0]  row_above[MaxWidth];
      logic [PixW-1:0]  row_two_above[MaxWidth];
      logic [PixW-1:0]  taps[6];
      int unsigned      col_pos;
      int unsigned      row_pos;
      bit               in_frame;
      blur_result_type  expected_blurs[$];
      int               mismatch_count;
      int               checked_count;

      function new();
         width_reg  = CfgW'(640);
         height_reg = CfgW'(480);
         foreach (row_above[i]) begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
         end
         foreach (taps[i]) taps[i] = '0;
         col_pos = 0;
         row_pos = 0;
         in_frame = 0;
         mismatch_count = 0;
         checked_count = 0;
      endfunction

      function void write_reg(csr_reg_type index, logic [CfgW-1:0] value);
         if (index == CSR_IMAGE_WIDTH) width_reg = value;
         else height_reg = value;
      endfunction

      // Consumes one accepted pixel beat; returns 1 if it belonged to a frame.
      function bit take_pixel(logic [PixW-1:0] pix, bit start);
         int unsigned w, h, c, r, idx, sum;
         logic [PixW-1:0] top, mid;
         bit row_end, frame_end;
         blur_result_type res;
         w = width_reg;
         if (w < 16) w = 16;
         if (w > MaxWidth) w = MaxWidth;
         h = height_reg;
         if (h < 16) h = 16;
         if (start) begin
            col_pos = 0;
            row_pos = 0;
            in_frame = 1;
         end
         if (!in_frame) return 0;
         c = col_pos;
         r = row_pos;
         idx = c % MaxWidth;
         top = row_two_above[idx];
         mid = row_above[idx];
         row_two_above[idx] = mid;
         row_above[idx] = pix;
         row_end = (c >= w - 1);
         frame_end = row_end && (r >= h - 1);
         // Interior pixel: centered on column c-1 of the row above.
         if (c >= 2 && r >= 2) begin
            sum = taps[0] + 2 * taps[3] + top
                + 2 * (taps[1] + 2 * taps[4] + mid)
                + taps[2] + 2 * taps[5] + pix;
            res.smoothed = PixW'((sum + 8) >> 4);
            res.col = ColW'(c - 1);
            res.row = RowW'(r - 1);
            res.last = frame_end;
            expected_blurs.push_back(res);
         end
         taps[0] = taps[3];
         taps[1] = taps[4];
         taps[2] = taps[5];
         taps[3] = top;
         taps[4] = mid;
         taps[5] = pix;
         if (frame_end) begin
            in_frame = 0;
            col_pos = 0;
            row_pos = 0;
         end else if (row_end) begin
            col_pos = 0;
            row_pos = (r + 1) & 12'hFFF;
         end else begin
            col_pos = c + 1;
         end
         return 1;
      endfunction

      // Compares one result beat with the oldest smoothed pixel due.
      function void check_blur(logic [RspW-1:0] data, logic last);
         blur_result_type exp_res;
         checked_count++;
         if (expected_blurs.size() == 0) begin
            $error("result beat with no smoothed pixel due: tdata %h", data);
            mismatch_count++;
            return;
         end
         exp_res = expected_blurs.pop_front();
         if (data[7:0] !== exp_res.smoothed) begin
            $error("smoothed: expected %0d, actual %0d", exp_res.smoothed, data[7:0]);
            mismatch_count++;
         end
         if (data[18:8] !== exp_res.col) begin
            $error("out_col: expected %0d, actual %0d", exp_res.col, data[18:8]);
            mismatch_count++;
         end
         if (data[30:19] !== exp_res.row) begin
            $error("out_row: expected %0d, actual %0d", exp_res.row, data[30:19]);
            mismatch_count++;
         end
         if (data[31] !== 1'b0) begin
            $error("pad: expected 0, actual %b", data[31]);
            mismatch_count++;
         end
         if (last !== exp_res.last) begin
            $error("last: expected %0d, actual %0d", exp_res.last, last);
            mismatch_count++;
         end
      endfunction

      function int pending();
         return expected_blurs.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic                csr_index = 1'b0;
   logic [CfgW-1:0]     csr_wdata = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [PixW-1:0]     req_tdata = '0;
   logic                req_tuser = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspW-1:0]     rsp_tdata;
   logic                rsp_tlast;

   blur_predictor board = new();
   int    cycle_count = 0;
   int    beats_sent = 0;
   int    frame_beats = 0;
   int    size_settings = 0;
   int    hold_left = 0;
   bit    hold_start = 0;
   bit    no_idle = 0;

   gaussian_3x3_filter i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due",
                  cycle_count, board.pending());
         $display("end of test: mismatches");
         $finish;
      end
   end

   function bit idle_now();
      return !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
   endfunction

   // Result side: random stalls plus one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_start) begin
            hold_start = 0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !idle_now();
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) board.check_blur(rsp_tdata, rsp_tlast);
      end
   end

   // Offers one pixel beat; entered and left at a falling edge.
   task automatic send_pixel(input logic [PixW-1:0] pix, input bit start);
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      req_tuser <= start;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      if (board.take_pixel(pix, start)) frame_beats++;
      @(negedge clock);
   endtask

   // Stops offering and waits until every smoothed pixel due has arrived.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes both frame size registers; the block must be idle.
   task automatic write_size(input logic [CfgW-1:0] w_raw, input logic [CfgW-1:0] h_raw);
      csr_we <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w_raw;
      @(negedge clock);
      board.write_reg(CSR_IMAGE_WIDTH, w_raw);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h_raw;
      @(negedge clock);
      board.write_reg(CSR_IMAGE_HEIGHT, h_raw);
      csr_we <= 1'b0;
      @(negedge clock);
      size_settings++;
   endtask

   function automatic logic [PixW-1:0] pick_pixel(pix_mode_type mode, int c, int r);
      case (mode)
         PIX_BLACK:   return 8'h00;
         PIX_WHITE:   return 8'hFF;
         PIX_CHECKER: return ((c + r) % 2 == 0) ? 8'hFF : 8'h00;
         PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default:     return PixW'($urandom_range(0, 255));
      endcase
   endfunction

   // Sends the first n pixels of a w-wide frame, pausing once if asked.
   task automatic send_frame(input int w, input int n, input pix_mode_type mode,
                             input int pause_at);
      for (int k = 0; k < n; k++) begin
         if (k == pause_at) drain();
         send_pixel(pick_pixel(mode, k % w, k / w), k == 0);
      end
   endtask

   function automatic int clamp_width(int raw);
      if (raw < 16) return 16;
      if (raw > MaxWidth) return MaxWidth;
      return raw;
   endfunction

   initial begin
      int w_raw, h_raw, w, h, n, frame_no, nframes;
      bit full;
      pix_mode_type mode;
      frame_no = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: sizes below range clamp to 16 by 16.
      write_size(CfgW'(0), CfgW'(0));
      // Pixels before any frame start are dropped.
      send_pixel(8'h00, 0);
      send_pixel(8'hFF, 0);
      send_pixel(8'hA5, 0);
      // A frame begins, then restarts from the origin in the middle.
      send_pixel(8'hFF, 1);
      for (int k = 0; k < 9; k++) send_pixel((k % 2) ? 8'hFF : 8'h00, 0);
      send_pixel(8'h00, 1);
      for (int k = 0; k < 10; k++) send_pixel(8'h5A ^ PixW'(k), 0);

      // Full frames of flat and checker content; pixels after the end are dropped.
      // The flat frame runs with no idling on either side.
      no_idle = 1;
      send_frame(16, 256, PIX_WHITE, -1);
      no_idle = 0;
      send_pixel(8'h12, 0);
      send_pixel(8'hED, 0);
      send_frame(16, 256, PIX_CHECKER, -1);
      send_pixel(8'hFF, 0);
      drain();

      // Widest row (clamped from all ones): a short run inside the first row
      // must give no result.
      write_size(CfgW'(4095), CfgW'(4095));
      send_frame(MaxWidth, 150, PIX_RANDOM, -1);
      drain();

      // Narrowest row with the tallest height, frame cut short.
      write_size(CfgW'(16), CfgW'(4095));
      send_frame(16, 16 * 20, PIX_EXTREME, -1);
      drain();

      // Random frames of small sizes, mostly complete, some cut short.
      while (beats_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 19))
            0, 1, 2:  w_raw = $urandom_range(0, 15);
            3, 4:     w_raw = $urandom_range(29, 64);
            default:  w_raw = $urandom_range(16, 28);
         endcase
         h_raw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(16, 20);
         drain();
         write_size(CfgW'(w_raw), CfgW'(h_raw));
         w = clamp_width(w_raw);
         h = (h_raw < 16) ? 16 : h_raw;
         nframes = $urandom_range(1, 3);
         for (int f = 0; f < nframes && beats_sent < ITEM_TARGET; f++) begin
            frame_no++;
            no_idle = (frame_no == 5 || frame_no == 6);
            // The result side holds off while the frame keeps coming.
            if (frame_no == 2) hold_start = 1;
            full = (frame_no == 2) || ($urandom_range(0, 99) < 75);
            n = full ? w * h : $urandom_range(1, w * h - 1);
            // Keep the run near its item budget.
            if (n > ITEM_TARGET - beats_sent) begin
               n = ITEM_TARGET - beats_sent;
               full = 0;
            end
            mode = ($urandom_range(0, 4) == 0) ? pix_mode_type'($urandom_range(1, 4))
                                               : PIX_RANDOM;
            send_frame(w, n, mode, (frame_no == 3) ? n / 2 : -1);
            if (full) repeat ($urandom_range(0, 4)) send_pixel(PixW'($urandom), 0);
         end
      end
      no_idle = 0;
      drain();
      repeat (10) @(posedge clock);

      $display("%0d pixel beats sent (%0d inside frames), %0d result beats checked,",
               beats_sent, frame_beats, board.checked_count);
      $display("%0d frame size settings including clamped and widest rows", size_settings);
      if (board.mismatch_count == 0 && board.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/gf3_pkg.sv
hw/rtl/gf3_line_ram.sv
hw/rtl/gf3_ctrl.sv
hw/rtl/gf3_window.sv
hw/rtl/gaussian_3x3_filter.sv
hw/rtl/gf3_checker.sv
test/gaussian_3x3_filter_tb.sv
